// ===== sv/tcw_pkg.sv =====
// shared types, constants and codes of the text console writer
package tcw_pkg;

  localparam int unsigned COLUMNS_DEF  = 80;
  localparam int unsigned ROWS_DEF     = 25;
  localparam int unsigned TAB_STOP_DEF = 8;

  localparam int unsigned POS_W  = 11;
  localparam int unsigned IDX_W  = 11;
  localparam int unsigned CELL_W = 16;

  localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0F20;

  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;

  typedef enum logic [1:0] {
    OP_PUT   = 2'd0,
    OP_CLEAR = 2'd1,
    OP_ERASE = 2'd2,
    OP_READ  = 2'd3
  } opcode_e;

  typedef struct packed {
    opcode_e          opcode;
    logic [7:0]       char_code;
    logic [3:0]       bg_nibble;
    logic [3:0]       fg_nibble;
    logic [IDX_W-1:0] cell_index;
  } in_item_t;

  typedef struct packed {
    logic [POS_W-1:0]  cursor_position;
    logic [CELL_W-1:0] cell_data;
    logic              did_scroll;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_RDATA,
    ST_COPY,
    ST_DRAIN,
    ST_FILL,
    ST_DONE
  } ctrl_state_e;

  typedef struct packed {
    logic latch;
    logic exec;
    logic rd_capture;
    logic copy_init;
    logic copy_step;
    logic drain;
    logic fill_init_all;
    logic fill_step;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    opcode_e op;
    logic    scroll;
    logic    cnt_end;
  } ctrl_status_t;

endpackage

// ===== sv/tcw_ram.sv =====
// generic single write port ram with registered read
module tcw_ram #(
  parameter int unsigned WIDTH  = 16,
  parameter int unsigned DEPTH  = 2000,
  parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/tcw_datapath.sv =====
// cursor, sweep counter, ram access muxing and result registers
module tcw_datapath
  import tcw_pkg::*;
#(
  parameter int unsigned COLUMNS  = COLUMNS_DEF,
  parameter int unsigned ROWS     = ROWS_DEF,
  parameter int unsigned TAB_STOP = TAB_STOP_DEF,
  parameter int unsigned ADDR_W   = $clog2(COLUMNS * ROWS)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  in_item_t          in_item_i,
  input  ctrl_cmd_t         cmd_i,
  output ctrl_status_t      status_o,
  output out_item_t         out_item_o,
  output logic              ram_we_o,
  output logic [ADDR_W-1:0] ram_waddr_o,
  output logic [CELL_W-1:0] ram_wdata_o,
  output logic [ADDR_W-1:0] ram_raddr_o,
  input  logic [CELL_W-1:0] ram_rdata_i
);

  localparam int unsigned CELLS = COLUMNS * ROWS;
  localparam int unsigned COL_W = $clog2(COLUMNS);
  localparam int unsigned ROW_W = $clog2(ROWS);
  localparam int unsigned PH_W  = $clog2(TAB_STOP);
  localparam int unsigned TMP_W = $clog2(COLUMNS + TAB_STOP + 1);

  localparam logic [COL_W-1:0]  LAST_COL    = COL_W'(COLUMNS - 1);
  localparam logic [ROW_W-1:0]  LAST_ROW    = ROW_W'(ROWS - 1);
  localparam logic [PH_W-1:0]   LAST_PH     = PH_W'(TAB_STOP - 1);
  localparam logic [PH_W-1:0]   LAST_COL_PH = PH_W'((COLUMNS - 1) % TAB_STOP);
  localparam logic [ADDR_W-1:0] LAST_CELL   = ADDR_W'(CELLS - 1);
  localparam logic [ADDR_W-1:0] ROW_BASE    = ADDR_W'((ROWS - 1) * COLUMNS);
  localparam logic [ADDR_W-1:0] COPY_BASE   = ADDR_W'(COLUMNS);

  in_item_t          item_q;
  logic [COL_W-1:0]  col_q, col_d, nxt_col;
  logic [ROW_W-1:0]  row_q, row_d, nxt_row;
  logic [PH_W-1:0]   ph_q, ph_d, nxt_ph;
  logic [ADDR_W-1:0] cnt_q, cnt_d;
  logic              pend_q, pend_d;
  logic [ADDR_W-1:0] wr_addr_q, wr_addr_d;
  logic [CELL_W-1:0] res_data_q, res_data_d;
  logic              res_scroll_q, res_scroll_d;
  out_item_t         out_q;

  logic [TMP_W-1:0]  tab_col;
  logic              adv_row;
  logic              scroll_now;
  logic              exec_we;
  logic              exec_blank;
  logic [ADDR_W-1:0] cur_addr;
  logic [ADDR_W-1:0] pos_d;
  logic              idx_ok;

  assign tab_col = TMP_W'(col_q) + TMP_W'(TAB_STOP) - TMP_W'(ph_q);

  // cursor update for the latched operation
  always_comb begin
    nxt_col    = col_q;
    nxt_row    = row_q;
    nxt_ph     = ph_q;
    adv_row    = 1'b0;
    scroll_now = 1'b0;
    exec_we    = 1'b0;
    exec_blank = 1'b0;
    unique case (item_q.opcode)
      OP_PUT: begin
        if (item_q.char_code == CH_BS) begin
          if (col_q != '0) begin
            nxt_col = col_q - 1'b1;
            nxt_ph  = (ph_q == '0) ? LAST_PH : ph_q - 1'b1;
          end
        end else if (item_q.char_code == CH_TAB) begin
          nxt_ph = '0;
          if (tab_col >= TMP_W'(COLUMNS)) begin
            nxt_col = '0;
            adv_row = 1'b1;
          end else begin
            nxt_col = COL_W'(tab_col);
          end
        end else if (item_q.char_code == CH_CR) begin
          nxt_col = '0;
          nxt_ph  = '0;
        end else if (item_q.char_code == CH_LF) begin
          nxt_col = '0;
          nxt_ph  = '0;
          adv_row = 1'b1;
        end else if (item_q.char_code >= CH_SPACE && !item_q.char_code[7]) begin
          exec_we = 1'b1;
          if (col_q == LAST_COL) begin
            nxt_col = '0;
            nxt_ph  = '0;
            adv_row = 1'b1;
          end else begin
            nxt_col = col_q + 1'b1;
            nxt_ph  = (ph_q == LAST_PH) ? '0 : ph_q + 1'b1;
          end
        end
        if (adv_row) begin
          if (row_q == LAST_ROW) begin
            scroll_now = 1'b1;
          end else begin
            nxt_row = row_q + 1'b1;
          end
        end
      end
      OP_CLEAR: begin
        nxt_col = '0;
        nxt_row = '0;
        nxt_ph  = '0;
      end
      OP_ERASE: begin
        if (col_q != '0 || row_q != '0) begin
          exec_we    = 1'b1;
          exec_blank = 1'b1;
          if (col_q != '0) begin
            nxt_col = col_q - 1'b1;
            nxt_ph  = (ph_q == '0) ? LAST_PH : ph_q - 1'b1;
          end else begin
            nxt_col = LAST_COL;
            nxt_ph  = LAST_COL_PH;
            nxt_row = row_q - 1'b1;
          end
        end
      end
      OP_READ: begin
        nxt_col = col_q;
      end
      default: begin
        nxt_col = col_q;
      end
    endcase
  end

  assign col_d = cmd_i.exec ? nxt_col : col_q;
  assign row_d = cmd_i.exec ? nxt_row : row_q;
  assign ph_d  = cmd_i.exec ? nxt_ph  : ph_q;

  assign cur_addr = ADDR_W'(row_q) * ADDR_W'(COLUMNS) + ADDR_W'(col_q);
  assign pos_d    = ADDR_W'(row_d) * ADDR_W'(COLUMNS) + ADDR_W'(col_d);
  assign idx_ok   = 32'(item_q.cell_index) < 32'(CELLS);

  // sweep counter and copy pipeline bookkeeping
  always_comb begin
    cnt_d     = cnt_q;
    pend_d    = pend_q;
    wr_addr_d = wr_addr_q;
    priority if (cmd_i.copy_init) begin
      cnt_d  = COPY_BASE;
      pend_d = 1'b0;
    end else if (cmd_i.fill_init_all) begin
      cnt_d = '0;
    end else if (cmd_i.drain) begin
      cnt_d = ROW_BASE;
    end else if (cmd_i.copy_step) begin
      cnt_d     = cnt_q + 1'b1;
      pend_d    = 1'b1;
      wr_addr_d = cnt_q - COPY_BASE;
    end else if (cmd_i.fill_step) begin
      cnt_d = cnt_q + 1'b1;
    end else begin
      cnt_d = cnt_q;
    end
  end

  // ram port muxing
  always_comb begin
    ram_we_o    = 1'b0;
    ram_waddr_o = cnt_q;
    ram_wdata_o = BLANK_CELL;
    priority if (cmd_i.fill_step) begin
      ram_we_o = 1'b1;
    end else if ((cmd_i.copy_step && pend_q) || cmd_i.drain) begin
      ram_we_o    = 1'b1;
      ram_waddr_o = wr_addr_q;
      ram_wdata_o = ram_rdata_i;
    end else if (cmd_i.exec && exec_we) begin
      ram_we_o    = 1'b1;
      ram_waddr_o = exec_blank ? pos_d : cur_addr;
      ram_wdata_o = exec_blank ? BLANK_CELL
                               : {item_q.bg_nibble, item_q.fg_nibble, item_q.char_code};
    end else begin
      ram_we_o = 1'b0;
    end
  end

  assign ram_raddr_o = cmd_i.copy_step ? cnt_q : ADDR_W'(item_q.cell_index);

  always_comb begin
    res_data_d   = res_data_q;
    res_scroll_d = res_scroll_q;
    if (cmd_i.exec) begin
      res_data_d   = '0;
      res_scroll_d = scroll_now;
    end else if (cmd_i.rd_capture) begin
      res_data_d = idx_ok ? ram_rdata_i : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      ph_q   <= '0;
      cnt_q  <= '0;
      pend_q <= 1'b0;
    end else begin
      col_q  <= col_d;
      row_q  <= row_d;
      ph_q   <= ph_d;
      cnt_q  <= cnt_d;
      pend_q <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      item_q <= in_item_i;
    end
    wr_addr_q    <= wr_addr_d;
    res_data_q   <= res_data_d;
    res_scroll_q <= res_scroll_d;
    if (cmd_i.out_load) begin
      out_q.cursor_position <= POS_W'(pos_d);
      out_q.cell_data       <= res_data_d;
      out_q.did_scroll      <= res_scroll_d;
    end
  end

  assign status_o.op      = item_q.opcode;
  assign status_o.scroll  = scroll_now;
  assign status_o.cnt_end = (cnt_q == LAST_CELL);
  assign out_item_o       = out_q;

endmodule

// ===== sv/tcw_ctrl.sv =====
// controller state machine and output valid flag
module tcw_ctrl
  import tcw_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  input  ctrl_status_t status_i,
  output ctrl_cmd_t    cmd_o
);

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        out_free;

  // output slot is free when empty or being drained this cycle
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_INIT: begin
        if (status_i.cnt_end) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        unique case (status_i.op)
          OP_PUT: begin
            if (status_i.scroll) begin
              state_d = ST_COPY;
            end else begin
              state_d = out_free ? ST_IDLE : ST_DONE;
            end
          end
          OP_CLEAR: state_d = ST_FILL;
          OP_ERASE: state_d = out_free ? ST_IDLE : ST_DONE;
          OP_READ:  state_d = ST_RDATA;
          default:  state_d = ST_IDLE;
        endcase
      end
      ST_RDATA: state_d = out_free ? ST_IDLE : ST_DONE;
      ST_COPY: begin
        if (status_i.cnt_end) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: state_d = ST_FILL;
      ST_FILL: begin
        if (status_i.cnt_end) begin
          state_d = out_free ? ST_IDLE : ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_INIT: cmd_o.fill_step = 1'b1;
      ST_IDLE: begin
        in_ready_o  = 1'b1;
        cmd_o.latch = in_valid_i;
      end
      ST_EXEC: begin
        cmd_o.exec = 1'b1;
        unique case (status_i.op)
          OP_PUT: begin
            cmd_o.copy_init = status_i.scroll;
            cmd_o.out_load  = !status_i.scroll && out_free;
          end
          OP_CLEAR: cmd_o.fill_init_all = 1'b1;
          OP_ERASE: cmd_o.out_load = out_free;
          OP_READ:  cmd_o.out_load = 1'b0;
          default:  cmd_o.out_load = 1'b0;
        endcase
      end
      ST_RDATA: begin
        cmd_o.rd_capture = 1'b1;
        cmd_o.out_load   = out_free;
      end
      ST_COPY:  cmd_o.copy_step = 1'b1;
      ST_DRAIN: cmd_o.drain = 1'b1;
      ST_FILL: begin
        cmd_o.fill_step = 1'b1;
        cmd_o.out_load  = status_i.cnt_end && out_free;
      end
      ST_DONE:  cmd_o.out_load = out_free;
      default:  cmd_o = '0;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== sv/text_console_writer.sv =====
// text console writer: screen store, cursor and operation sequencing
//
// Input channel in_valid_i/in_ready_o carries one operation per transaction
// (put character, clear screen, erase backspace, read cell). Output channel
// out_valid_o/out_ready_i returns exactly one result per operation: the
// cursor position row*COLUMNS+column, the cell read and a scroll flag.
// Put and erase execute in the EXEC state, which loads the result
// register unless a result still waits; read cell adds a state that
// captures the ram read. A new transaction is accepted only after the
// previous operation is through. A put that scrolls copies every cell one
// row up through the screen ram's single write port and then blanks the
// bottom row. Clear screen sweeps all ROWS*COLUMNS cells. After reset the
// block blanks all ROWS*COLUMNS cells (2000 at 80x25) with in_ready_o low,
// then the cursor sits at home.
// One result register sits at the output: the next transaction is taken
// while a result waits, and that operation's result is held back until
// the receiver takes the waiting one.
module text_console_writer
  import tcw_pkg::*;
#(
  parameter int unsigned COLUMNS  = COLUMNS_DEF,
  parameter int unsigned ROWS     = ROWS_DEF,
  parameter int unsigned TAB_STOP = TAB_STOP_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  localparam int unsigned CELLS  = COLUMNS * ROWS;
  localparam int unsigned ADDR_W = $clog2(CELLS);

  ctrl_cmd_t         cmd;
  ctrl_status_t      status;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [CELL_W-1:0] ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [CELL_W-1:0] ram_rdata;

  tcw_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  tcw_datapath #(
    .COLUMNS  (COLUMNS),
    .ROWS     (ROWS),
    .TAB_STOP (TAB_STOP),
    .ADDR_W   (ADDR_W)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_item_o  (out_item_o),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

  tcw_ram #(
    .WIDTH  (CELL_W),
    .DEPTH  (CELLS),
    .ADDR_W (ADDR_W)
  ) u_screen_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // one operation in flight at a time
  a_single_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("transaction accepted while an operation is in flight");

  // the screen is never written while waiting for a transaction
  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !ram_we)
    else $error("screen write while idle");

  // reported cursor always lies on the screen
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (CELLS > 2048) || (32'(out_item_o.cursor_position) < 32'(CELLS)))
    else $error("cursor position beyond the screen");

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// self-checking testbench of the text console writer: directed cases, then random text
module tb_top;
  import tcw_pkg::*;

  localparam int unsigned COLS         = COLUMNS_DEF;
  localparam int unsigned ROWS         = ROWS_DEF;
  localparam int unsigned TAB          = TAB_STOP_DEF;
  localparam int unsigned CELLS        = COLS * ROWS;
  localparam int unsigned RANDOM_ITEMS = 1950;
  localparam int unsigned IDLE_LIMIT   = 20000;
  localparam int unsigned DRAIN_CYCLES = 50;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_item;

  // expected screen contents and cursor
  logic [CELL_W-1:0] screen_copy [CELLS];
  int unsigned       cur_col = 0;
  int unsigned       cur_row = 0;
  out_item_t         expected_results [$];

  int unsigned items_sent = 0;
  int unsigned scroll_count = 0;
  int unsigned read_count = 0;
  int unsigned mismatches = 0;
  int unsigned idle_cycles = 0;
  int unsigned burst_left = 0;
  logic [31:0] ready_pattern = '1;
  logic [4:0]  ready_phase = '0;

  text_console_writer dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_item_o (out_item)
  );

  always #2 clk = ~clk;

  function automatic void blank_screen();
    for (int unsigned i = 0; i < CELLS; i++) screen_copy[i] = BLANK_CELL;
    cur_col = 0;
    cur_row = 0;
  endfunction

  // apply one operation to the expected screen and return its result
  function automatic out_item_t console_apply(input in_item_t item);
    out_item_t res;
    res = '0;
    case (item.opcode)
      OP_PUT: begin
        if (item.char_code == CH_BS) begin
          if (cur_col > 0) cur_col--;
        end else if (item.char_code == CH_TAB) begin
          cur_col = (cur_col / TAB + 1) * TAB;
        end else if (item.char_code == CH_CR) begin
          cur_col = 0;
        end else if (item.char_code == CH_LF) begin
          cur_col = 0;
          cur_row++;
        end else if (item.char_code >= CH_SPACE && !item.char_code[7]) begin
          screen_copy[cur_row * COLS + cur_col] =
            {item.bg_nibble, item.fg_nibble, item.char_code};
          cur_col++;
        end
        if (cur_col >= COLS) begin
          cur_col = 0;
          cur_row++;
        end
        if (cur_row >= ROWS) begin
          for (int unsigned i = 0; i < (ROWS - 1) * COLS; i++)
            screen_copy[i] = screen_copy[i + COLS];
          for (int unsigned i = (ROWS - 1) * COLS; i < CELLS; i++)
            screen_copy[i] = BLANK_CELL;
          cur_row = ROWS - 1;
          res.did_scroll = 1'b1;
        end
      end
      OP_CLEAR: blank_screen();
      OP_ERASE: begin
        if (cur_col != 0 || cur_row != 0) begin
          if (cur_col > 0) begin
            cur_col--;
          end else begin
            cur_col = COLS - 1;
            cur_row--;
          end
          screen_copy[cur_row * COLS + cur_col] = BLANK_CELL;
        end
      end
      default: begin
        if (item.cell_index < CELLS) res.cell_data = screen_copy[item.cell_index];
      end
    endcase
    res.cursor_position = POS_W'(cur_row * COLS + cur_col);
    return res;
  endfunction

  // every field random, then the opcode set
  function automatic in_item_t make_item(input opcode_e op);
    in_item_t    item;
    logic [31:0] bits;
    bits = $urandom();
    item = bits[$bits(in_item_t)-1:0];
    item.opcode = op;
    return item;
  endfunction

  // one input transaction, at burst ends often followed by a sender gap
  task automatic send_item(input in_item_t item);
    out_item_t res;
    in_valid <= 1'b1;
    in_item <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    res = console_apply(item);
    expected_results.push_back(res);
    items_sent++;
    if (res.did_scroll) scroll_count++;
    if (item.opcode == OP_READ) read_count++;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if ($urandom_range(0, 3) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end else begin
      burst_left--;
    end
  endtask

  task automatic send_put(input logic [7:0] ch, input logic [3:0] bg, input logic [3:0] fg);
    in_item_t item;
    item = make_item(OP_PUT);
    item.char_code = ch;
    item.bg_nibble = bg;
    item.fg_nibble = fg;
    send_item(item);
  endtask

  task automatic send_read(input logic [IDX_W-1:0] idx);
    in_item_t item;
    item = make_item(OP_READ);
    item.cell_index = idx;
    send_item(item);
  endtask

  task automatic test_reset_contents();
    send_read('0);
    send_read(IDX_W'(CELLS - 1));
    send_read(IDX_W'(CELLS));
    send_read('1);
  endtask

  task automatic test_erase_at_home();
    send_item(make_item(OP_ERASE));
  endtask

  task automatic test_printable_extremes();
    send_put(CH_SPACE, 4'h0, 4'h0);
    send_put(8'h7F, 4'hF, 4'hF);
    send_put(8'h41, 4'h5, 4'hA);
    send_read(IDX_W'(0));
    send_read(IDX_W'(1));
    send_read(IDX_W'(2));
  endtask

  task automatic test_ignored_bytes();
    send_put(8'h00, 4'h3, 4'hC);
    send_put(8'h1F, 4'h3, 4'hC);
    send_put(8'h80, 4'h3, 4'hC);
    send_put(8'hFF, 4'h3, 4'hC);
  endtask

  // backspace, return, backspace at column 0, tab, line feed
  task automatic test_control_codes();
    send_put(CH_BS, 4'h1, 4'h2);
    send_put(CH_CR, 4'h1, 4'h2);
    send_put(CH_BS, 4'h1, 4'h2);
    send_put(CH_TAB, 4'h1, 4'h2);
    send_put(CH_LF, 4'h1, 4'h2);
  endtask

  // erase at column 0 lands on the last column of the row above
  task automatic test_erase_wrap();
    send_item(make_item(OP_ERASE));
    send_read(IDX_W'(COLS - 1));
  endtask

  task automatic test_clear();
    send_item(make_item(OP_CLEAR));
    send_read(IDX_W'(1));
  endtask

  task automatic send_line_char();
    in_item_t item;
    int unsigned r;
    item = make_item(OP_PUT);
    r = $urandom_range(0, 99);
    if (r < 86) item.char_code = 8'($urandom_range(32, 127));
    else if (r < 92) item.char_code = CH_TAB;
    else if (r < 95) item.char_code = CH_BS;
    else if (r < 97) item.char_code = 8'($urandom_range(0, 31));
    else item.char_code = 8'($urandom_range(128, 255));
    send_item(item);
  endtask

  // text lines of mixed length with edits, reads and a little noise
  task automatic test_random_text();
    int unsigned start_count;
    int unsigned r;
    int unsigned len;
    int unsigned pos;
    in_item_t    item;
    start_count = items_sent;
    while (items_sent - start_count < RANDOM_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 60) begin
        len = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 12) : $urandom_range(40, 100);
        repeat (len) send_line_char();
        case ($urandom_range(0, 4))
          0, 1: send_put(CH_LF, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
          2: begin
            send_put(CH_CR, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
            send_put(CH_LF, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
          end
          3: send_put(CH_CR, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
          default: ;
        endcase
      end else if (r < 75) begin
        repeat ($urandom_range(1, 6)) send_item(make_item(OP_ERASE));
      end else if (r < 93) begin
        repeat ($urandom_range(1, 8)) begin
          pos = cur_row * COLS + cur_col;
          if ($urandom_range(0, 1) == 0)
            send_read(IDX_W'((pos + CELLS - $urandom_range(1, 90)) % CELLS));
          else
            send_read(IDX_W'($urandom_range(0, 2047)));
        end
      end else if (r < 98) begin
        repeat ($urandom_range(1, 5)) begin
          case ($urandom_range(0, 2))
            0: item = make_item(OP_PUT);
            1: item = make_item(OP_ERASE);
            default: item = make_item(OP_READ);
          endcase
          send_item(item);
        end
      end else begin
        send_item(make_item(OP_CLEAR));
      end
    end
  endtask

  // receiver stalls follow a 32-bit pattern, redrawn each time it runs out
  always @(posedge clk) begin
    out_ready <= ready_pattern[ready_phase];
    ready_phase <= ready_phase + 1'b1;
    if (ready_phase == 5'd31) begin
      case ($urandom_range(0, 3))
        0: ready_pattern <= '1;
        1: ready_pattern <= $urandom();
        2: ready_pattern <= $urandom() & $urandom();
        default: ready_pattern <= $urandom() | $urandom();
      endcase
    end
  end

  function automatic void check_field(input string field, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      if (mismatches < 10)
        $display("mismatch on %s: expected 0x%0h, got 0x%0h", field, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        if (mismatches < 10) $display("mismatch: result transaction with none expected");
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        check_field("cursor_position", 32'(want.cursor_position), 32'(out_item.cursor_position));
        check_field("cell_data", 32'(want.cell_data), 32'(out_item.cell_data));
        check_field("did_scroll", 32'(want.did_scroll), 32'(out_item.did_scroll));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    blank_screen();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_contents();
    test_erase_at_home();
    test_printable_extremes();
    test_ignored_bytes();
    test_control_codes();
    test_erase_wrap();
    test_clear();
    test_random_text();

    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("ran %0d console operations, %0d of them cell reads", items_sent, read_count);
    $display("screen scrolled %0d times, %0d results missing at the end",
             scroll_count, expected_results.size());
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
